[design/assert_macros.svh]
// assertion macros used by the float unit top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define EEFA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define EEFA_NEVER(lbl, clk, rstn, expr) \
  `EEFA_ASSERT(lbl, clk, rstn, !(expr))
`else
`define EEFA_ASSERT(lbl, clk, rstn, prop)
`define EEFA_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[design/eefa_pkg.sv]
// types and codes for the extended exponent float unit
package eefa_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SETUP,
    ST_LOAD,
    ST_ALIGN,
    ST_CMP,
    ST_SUB,
    ST_ADD,
    ST_MUL,
    ST_DIV,
    ST_NORMR,
    ST_ROUND
  } state_e;

  typedef enum logic [1:0] {
    SEL_ACC_Y,
    SEL_MUL,
    SEL_DIV
  } alu_sel_e;

  typedef struct packed {
    alu_sel_e sel;
    logic     inv;
    logic     cin;
  } alu_ctrl_t;

endpackage

[design/eefa_alu.sv]
// shared mantissa adder with operand selection for add, multiply and divide steps
module eefa_alu import eefa_pkg::*; #(
  parameter int MANT_BITS = 53
) (
  input  alu_ctrl_t                 ctrl_i,
  input  logic [2*MANT_BITS+3:0]    acc_i,
  input  logic [2*MANT_BITS+3:0]    y_i,
  input  logic [MANT_BITS-1:0]      ma_i,
  input  logic [MANT_BITS-1:0]      mb_i,
  output logic [2*MANT_BITS+3:0]    sum_o,
  output logic                      carry_o
);

  localparam int FW = 2 * MANT_BITS + 4;

  logic [FW-1:0] opa;
  logic [FW-1:0] opb;
  logic [FW-1:0] opb_x;

  always_comb begin
    case (ctrl_i.sel)
      SEL_ACC_Y: begin
        opa = acc_i;
        opb = y_i;
      end
      SEL_MUL: begin
        opa = {acc_i[FW-2:0], 1'b0};
        opb = mb_i[MANT_BITS-1] ? FW'(ma_i) : '0;
      end
      SEL_DIV: begin
        opa = y_i;
        opb = FW'(mb_i);
      end
      default: begin
        opa = acc_i;
        opb = y_i;
      end
    endcase
    opb_x = ctrl_i.inv ? ~opb : opb;
  end

  assign {carry_o, sum_o} = {1'b0, opa} + {1'b0, opb_x} + (FW + 1)'(ctrl_i.cin);

endmodule

[design/extended_exponent_float_alu.sv]
// extended exponent float add, subtract, multiply and divide unit
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  cmd, operands a and b
// m_axis    out  m_axis_tvalid / m_axis_tready  result, exp_overflow, div_by_zero
//
// a request passes through operand normalize shifts, setup, load, the work,
// result normalize shifts and rounding; multiply and divide work one bit per
// cycle through the shared adder, add/sub aligns, then adds or compares and
// subtracts; a zero operand skips the load and the work
// reset clears the sequencer and the output valid; no clearing pass
// a result waits in the output register and the next request is taken meanwhile;
// the rounding step holds while that register is still full
`include "assert_macros.svh"

module extended_exponent_float_alu import eefa_pkg::*; #(
  parameter int MANT_BITS = 53,
  parameter int EXP_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cmd, a_sign, a_mant, a_exp, b_sign, b_mant, b_exp, zero fill
  input  logic [((2+2*(1+MANT_BITS+EXP_BITS)+7)/8)*8-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // r_sign, r_mant, r_exp, exp_overflow, div_by_zero, zero fill
  output logic [((MANT_BITS+EXP_BITS+3+7)/8)*8-1:0]       m_axis_tdata
);

  localparam int MB        = MANT_BITS;
  localparam int EB        = EXP_BITS;
  localparam int FW        = 2 * MB + 4;
  localparam int XW        = EB + 10;
  localparam int G         = MB + 3;
  localparam int ALIGN_MAX = 2 * MB + 3;
  localparam int CW        = $clog2(FW);
  localparam int OUT_W     = MB + EB + 3;
  localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8;
  localparam int O_ASIGN   = 2;
  localparam int O_AMANT   = 3;
  localparam int O_AEXP    = 3 + MB;
  localparam int O_BSIGN   = 3 + MB + EB;
  localparam int O_BMANT   = 4 + MB + EB;
  localparam int O_BEXP    = 4 + 2 * MB + EB;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic                 sa_q, sa_d, sb_q, sb_d, rs_q, rs_d, st_q, st_d, dz_q, dz_d;
  logic [MB-1:0]        ma_q, ma_d, mb_q, mb_d;
  logic signed [XW-1:0] ea_q, ea_d, eb_q, eb_d, e_q, e_d;
  logic [FW-1:0]        acc_q, acc_d, y_q, y_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_sign_q, out_sign_d, out_ovf_q, out_ovf_d, out_dz_q, out_dz_d;
  logic [MB-1:0]        out_mant_q, out_mant_d;
  logic [EB-1:0]        out_exp_q, out_exp_d;

  alu_ctrl_t            alu_ctrl;
  logic [FW-1:0]        alu_sum;
  logic                 alu_carry;

  logic                 in_fire;
  logic signed [XW-1:0] diff;
  logic [MB-1:0]        rnd_m;
  logic                 rnd_rb, rnd_stk, rnd_inc;
  logic [MB:0]          rnd_sum;
  logic signed [XW-1:0] rnd_e;
  logic [XW-EB:0]       rnd_hi;

  eefa_alu #(.MANT_BITS(MB)) u_alu (
    .ctrl_i  (alu_ctrl),
    .acc_i   (acc_q),
    .y_i     (y_q),
    .ma_i    (ma_q),
    .mb_i    (mb_q),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({out_dz_q, out_ovf_q, out_exp_q, out_mant_q, out_sign_q});

  // rounding of the normalized accumulator
  always_comb begin
    diff    = ea_q - eb_q;
    rnd_m   = acc_q[FW-1 -: MB];
    rnd_rb  = acc_q[FW-1-MB];
    rnd_stk = (|acc_q[FW-2-MB:0]) | st_q;
    rnd_inc = rnd_rb & (rnd_stk | rnd_m[0]);
    rnd_sum = {1'b0, rnd_m} + (MB + 1)'(rnd_inc);
    rnd_e   = e_q + XW'(rnd_sum[MB]);
    rnd_hi  = rnd_e[XW-1:EB-1];
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    rs_d        = rs_q;
    st_d        = st_q;
    dz_d        = dz_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    e_d         = e_q;
    acc_d       = acc_q;
    y_d         = y_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_sign_d  = out_sign_q;
    out_mant_d  = out_mant_q;
    out_exp_d   = out_exp_q;
    out_ovf_d   = out_ovf_q;
    out_dz_d    = out_dz_q;
    alu_ctrl    = '{sel: SEL_ACC_Y, inv: 1'b0, cin: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d   = cmd_e'(s_axis_tdata[1:0]);
          sa_d    = s_axis_tdata[O_ASIGN];
          sb_d    = s_axis_tdata[O_BSIGN] ^ (s_axis_tdata[1:0] == CMD_SUB);
          ma_d    = s_axis_tdata[O_AMANT +: MB];
          mb_d    = s_axis_tdata[O_BMANT +: MB];
          ea_d    = XW'($signed(s_axis_tdata[O_AEXP +: EB]));
          eb_d    = XW'($signed(s_axis_tdata[O_BEXP +: EB]));
          rs_d    = 1'b0;
          st_d    = 1'b0;
          dz_d    = 1'b0;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (ma_q != '0 && !ma_q[MB-1]) begin
          ma_d = ma_q << 1;
          ea_d = ea_q - XW'(1);
        end else if (mb_q != '0 && !mb_q[MB-1]) begin
          mb_d = mb_q << 1;
          eb_d = eb_q - XW'(1);
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_LOAD;
        case (cmd_q)
          CMD_ADD, CMD_SUB: begin
            if (ma_q == '0) begin
              acc_d   = {mb_q, (FW - MB)'(0)};
              e_d     = eb_q;
              rs_d    = sb_q;
              state_d = ST_NORMR;
            end else if (mb_q == '0) begin
              acc_d   = {ma_q, (FW - MB)'(0)};
              e_d     = ea_q;
              rs_d    = sa_q;
              state_d = ST_NORMR;
            end else if (ea_q < eb_q) begin
              ma_d = mb_q;
              mb_d = ma_q;
              ea_d = eb_q;
              eb_d = ea_q;
              sa_d = sb_q;
              sb_d = sa_q;
            end
          end
          CMD_MUL: begin
            if (ma_q == '0 || mb_q == '0) begin
              acc_d   = '0;
              state_d = ST_NORMR;
            end
          end
          default: begin
            if (ma_q == '0) begin
              acc_d   = '0;
              state_d = ST_NORMR;
            end else if (mb_q == '0) begin
              acc_d   = '0;
              dz_d    = 1'b1;
              state_d = ST_NORMR;
            end
          end
        endcase
      end
      ST_LOAD: begin
        case (cmd_q)
          CMD_ADD, CMD_SUB: begin
            acc_d   = {1'b0, ma_q, G'(0)};
            y_d     = {1'b0, mb_q, G'(0)};
            cnt_d   = (diff >= $signed(XW'(ALIGN_MAX))) ? CW'(ALIGN_MAX) : diff[CW-1:0];
            e_d     = ea_q + XW'(1);
            state_d = ST_ALIGN;
          end
          CMD_MUL: begin
            acc_d   = '0;
            cnt_d   = CW'(MB);
            e_d     = ea_q + eb_q + XW'(4);
            rs_d    = sa_q ^ sb_q;
            state_d = ST_MUL;
          end
          default: begin
            acc_d   = '0;
            y_d     = FW'(ma_q);
            cnt_d   = CW'(MB + 3);
            e_d     = diff + XW'(MB + 2);
            rs_d    = sa_q ^ sb_q;
            state_d = ST_DIV;
          end
        endcase
      end
      ST_ALIGN: begin
        if (cnt_q != '0) begin
          st_d  = st_q | y_q[0];
          y_d   = y_q >> 1;
          cnt_d = cnt_q - CW'(1);
        end else begin
          state_d = (sa_q == sb_q) ? ST_ADD : ST_CMP;
        end
      end
      ST_CMP: begin
        alu_ctrl = '{sel: SEL_ACC_Y, inv: 1'b1, cin: 1'b1};
        if (!alu_carry) begin
          acc_d = y_q;
          y_d   = acc_q;
          rs_d  = sb_q;
        end else begin
          rs_d  = sa_q;
        end
        state_d = ST_SUB;
      end
      ST_SUB: begin
        alu_ctrl = '{sel: SEL_ACC_Y, inv: 1'b1, cin: !st_q};
        acc_d    = alu_sum;
        state_d  = ST_NORMR;
      end
      ST_ADD: begin
        alu_ctrl = '{sel: SEL_ACC_Y, inv: 1'b0, cin: 1'b0};
        acc_d    = alu_sum;
        rs_d     = sa_q;
        state_d  = ST_NORMR;
      end
      ST_MUL: begin
        alu_ctrl = '{sel: SEL_MUL, inv: 1'b0, cin: 1'b0};
        if (cnt_q != '0) begin
          acc_d = alu_sum;
          mb_d  = mb_q << 1;
          cnt_d = cnt_q - CW'(1);
        end else begin
          state_d = ST_NORMR;
        end
      end
      ST_DIV: begin
        alu_ctrl = '{sel: SEL_DIV, inv: 1'b1, cin: 1'b1};
        if (cnt_q != '0) begin
          y_d   = (alu_carry ? alu_sum : y_q) << 1;
          acc_d = {acc_q[FW-2:0], alu_carry};
          cnt_d = cnt_q - CW'(1);
        end else begin
          st_d    = |y_q;
          state_d = ST_NORMR;
        end
      end
      ST_NORMR: begin
        if (acc_q != '0 && !acc_q[FW-1]) begin
          acc_d = acc_q << 1;
          e_d   = e_q - XW'(1);
        end else begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_dz_d    = dz_q;
          if (acc_q == '0) begin
            out_sign_d = 1'b0;
            out_mant_d = '0;
            out_exp_d  = '0;
            out_ovf_d  = 1'b0;
          end else begin
            out_sign_d = rs_q;
            out_mant_d = rnd_sum[MB] ? {1'b1, (MB - 1)'(0)} : rnd_sum[MB-1:0];
            out_exp_d  = rnd_e[EB-1:0];
            out_ovf_d  = !((&rnd_hi) || !(|rnd_hi));
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    sa_q       <= sa_d;
    sb_q       <= sb_d;
    rs_q       <= rs_d;
    st_q       <= st_d;
    dz_q       <= dz_d;
    ma_q       <= ma_d;
    mb_q       <= mb_d;
    ea_q       <= ea_d;
    eb_q       <= eb_d;
    e_q        <= e_d;
    acc_q      <= acc_d;
    y_q        <= y_d;
    out_sign_q <= out_sign_d;
    out_mant_q <= out_mant_d;
    out_exp_q  <= out_exp_d;
    out_ovf_q  <= out_ovf_d;
    out_dz_q   <= out_dz_d;
  end

  `EEFA_ASSERT(a_round_norm, clk_i, rst_ni, (state_q == ST_ROUND && acc_q != '0) |-> acc_q[FW-1])
  `EEFA_ASSERT(a_out_norm, clk_i, rst_ni, (out_valid_q && out_mant_q != '0) |-> out_mant_q[MB-1])
  `EEFA_ASSERT(a_dz_zero, clk_i, rst_ni, (out_valid_q && out_dz_q) |-> (out_mant_q == '0 && !out_ovf_q))
  `EEFA_ASSERT(a_start, clk_i, rst_ni, in_fire |=> (state_q == ST_NORM))
  `EEFA_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CW'(ALIGN_MAX))

endmodule

[tb/eefa_checker.sv]
// checker for the extended exponent float unit: predicts each request and compares results
module eefa_checker import eefa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [175:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [87:0]  m_data_i,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [52:0] MANT_TOP = 53'h10000000000000;

  logic [87:0] expected_results[$];

  function automatic void normalize(ref logic [52:0] m, ref longint e);
    if (m == 0) return;
    while (!m[52]) begin
      m = m << 1;
      e = e - 1;
    end
  endfunction

  function automatic logic [52:0] round_mant(logic [255:0] x, bit st, longint s,
                                             output longint e);
    int len;
    int k;
    bit stk;
    bit rb;
    logic [52:0] m;
    len = 0;
    for (int i = 255; i >= 0; i--)
      if (x[i]) begin
        len = i + 1;
        break;
      end
    e = s + len;
    if (len > 53) begin
      k = len - 54;
      stk = (|(x & ((256'b1 << k) - 1))) || st;
      x = x >> k;
      rb = x[0];
      x = x >> 1;
      m = x[52:0];
      if (rb && (stk || m[0])) begin
        m = m + 1;
        if (m == 0) begin
          m = MANT_TOP;
          e = e + 1;
        end
      end
    end else begin
      x = x << (53 - len);
      m = x[52:0];
    end
    return m;
  endfunction

  function automatic logic [87:0] float_result(logic [175:0] d);
    cmd_e op;
    bit sa, sb, rs, dz, tb;
    logic [52:0] am, bm, rm, tm;
    longint ea, eb, er, te, dif;
    int sh;
    bit st;
    logic [255:0] x, y, t;
    op = cmd_e'(d[1:0]);
    sa = d[2];
    am = d[55:3];
    ea = longint'($signed(d[87:56]));
    sb = d[88];
    bm = d[141:89];
    eb = longint'($signed(d[173:142]));
    rs = 0;
    rm = 0;
    er = 0;
    dz = 0;
    if (op == CMD_SUB) sb = !sb;
    normalize(am, ea);
    normalize(bm, eb);
    case (op)
      CMD_ADD, CMD_SUB: begin
        if (am == 0) begin
          rs = sb; rm = bm; er = eb;
        end else if (bm == 0) begin
          rs = sa; rm = am; er = ea;
        end else begin
          if (ea < eb) begin
            tm = am; te = ea; tb = sa;
            am = bm; ea = eb; sa = sb;
            bm = tm; eb = te; sb = tb;
          end
          dif = ea - eb;
          sh = (dif > 256) ? 256 : int'(dif);
          x = 256'(am) << 56;
          y = 256'(bm) << 56;
          st = |(y & ((256'b1 << sh) - 1));
          y = y >> sh;
          if (sa == sb) begin
            x = x + y;
            rs = sa;
          end else begin
            if (x < y) begin
              t = x; x = y; y = t; rs = sb;
            end else rs = sa;
            x = x - y;
            if (st) x = x - 1;
          end
          if (x != 0) rm = round_mant(x, st, ea - 109, er);
        end
      end
      CMD_MUL: begin
        if (am != 0 && bm != 0) begin
          rs = sa ^ sb;
          x = 256'(am) * 256'(bm);
          rm = round_mant(x, 0, ea + eb - 106, er);
        end
      end
      default: begin
        if (am != 0 && bm == 0) dz = 1;
        else if (am != 0) begin
          rs = sa ^ sb;
          t = 256'(am) << 108;
          x = t / 256'(bm);
          y = t % 256'(bm);
          rm = round_mant(x, y != 0, ea - eb - 108, er);
        end
      end
    endcase
    if (rm == 0) return {dz, 87'b0};
    return {dz, (er > 64'sd2147483647 || er < -64'sd2147483648), er[31:0], rm, rs};
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [87:0] want;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i) expected_results.push_back(float_result(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, m_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== m_data_i) begin
            $display("%0t mismatch: expected sign %b mant %h exp %h ovf %b dz %b",
                     $time, want[0], want[53:1], want[85:54], want[86], want[87]);
            $display("%0t           actual   sign %b mant %h exp %h ovf %b dz %b",
                     $time, m_data_i[0], m_data_i[53:1], m_data_i[85:54], m_data_i[86],
                     m_data_i[87]);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

[tb/testbench.sv]
// top of the float unit testbench: stimulus, idling, timeout and verdict
module testbench import eefa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [87:0]  m_axis_tdata;
  int           errors;
  int           pending;
  int           cycles = 0;
  bit           rx_busy_mode = 0;

  extended_exponent_float_alu dut (.*);

  eefa_checker checker_i (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
    if ($urandom_range(0, 199) == 0) rx_busy_mode <= !rx_busy_mode;
    if (rx_busy_mode) m_axis_tready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 30) != 0);
    else m_axis_tready <= 1;
  end

  task automatic send(cmd_e op, bit as, logic [52:0] am, logic [31:0] ae,
                      bit bs, logic [52:0] bm, logic [31:0] be);
    int g;
    s_axis_tdata <= {2'b0, be, bm, bs, ae, am, as, op};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [52:0] rand_mant();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0: return '0;
      1: return 53'({$urandom, $urandom}) >> $urandom_range(1, 52);
      2: return '1;
      3: return 53'h10000000000000;
      default: return {1'b1, 52'({$urandom, $urandom})};
    endcase
  endfunction

  function automatic logic [31:0] rand_exp();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom;
      1: return 32'h7fffffff - $urandom_range(0, 60);
      2: return 32'h80000000 + $urandom_range(0, 60);
      default: return 32'($urandom_range(0, 200)) - 32'd100;
    endcase
  endfunction

  initial begin
    logic [52:0] am, bm;
    logic [31:0] ae, be;
    cmd_e op;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(CMD_ADD, 0, 53'h10000000000000, 0, 0, 53'h10000000000000, 0);
    send(CMD_SUB, 0, '1, 5, 0, '1, 5);
    send(CMD_SUB, 1, '1, 5, 0, 53'h1fffffffffffff, 4);
    send(CMD_ADD, 0, 0, 7, 1, '1, 9);
    send(CMD_SUB, 0, 0, 7, 1, '1, 9);
    send(CMD_ADD, 1, '1, 3, 0, 0, 9);
    send(CMD_ADD, 0, 0, 0, 0, 0, 0);
    send(CMD_ADD, 0, '1, 32'h7fffffff, 0, '1, 32'h7fffffff);
    send(CMD_ADD, 0, '1, 1000, 1, 53'h10000000000001, -1000);
    send(CMD_ADD, 0, '1, 32'h7fffffff, 1, '1, 32'h80000000);
    send(CMD_MUL, 1, '1, 32'h7fffffff, 0, '1, 32'h7fffffff);
    send(CMD_MUL, 0, 53'h10000000000000, 32'h80000000, 1, 53'h10000000000000, 32'h80000000);
    send(CMD_MUL, 0, 0, 5, 0, '1, 5);
    send(CMD_MUL, 1, 53'h5, 0, 1, 53'h3, 0);
    send(CMD_DIV, 0, '1, 0, 0, 53'h10000000000000, 0);
    send(CMD_DIV, 1, 53'h15555555555555, 2, 0, 53'h18000000000000, 1);
    send(CMD_DIV, 0, '1, 3, 0, 0, 0);
    send(CMD_DIV, 0, 0, 3, 0, 0, 0);
    send(CMD_DIV, 0, 0, 3, 1, '1, 0);
    send(CMD_DIV, 0, 53'h10000000000000, 32'h80000000, 0, '1, 32'h7fffffff);
    send(CMD_DIV, 1, 53'h1, 32'h7fffffff, 1, 53'h3, 32'h80000000);
    send(CMD_SUB, 0, 53'h1, 0, 0, '1, -53);
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    wait (pending == 0);
    for (int i = 0; i < 650; i++) begin
      op = cmd_e'($urandom_range(0, 3));
      am = rand_mant();
      ae = rand_exp();
      bm = rand_mant();
      be = rand_exp();
      if ($urandom_range(0, 9) == 0) begin
        bm = am ^ 53'($urandom_range(0, 255));
        be = ae - 32'($urandom_range(0, 2));
        op = CMD_SUB;
      end
      send(op, 1'($urandom_range(0, 1)), am, ae, 1'($urandom_range(0, 1)), bm, be);
      if (i == 300) begin
        s_axis_tvalid <= 0;
        @(posedge clk_i);
        wait (pending == 0);
      end
    end
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
